[rtl/tsdf_pkg.sv]
// shared constants, codes and control types for the tagged sample demux fifo
`timescale 1ns / 1ps

package tsdf_pkg;

  // queue geometry
  localparam int GYRO_DEPTH  = 256;
  localparam int ACCEL_DEPTH = 256;
  localparam int G_AW = $clog2(GYRO_DEPTH);
  localparam int A_AW = $clog2(ACCEL_DEPTH);
  localparam int G_PW = $clog2(2 * GYRO_DEPTH);
  localparam int A_PW = $clog2(2 * ACCEL_DEPTH);

  // payload widths
  localparam int SAMPLE_W   = 48;
  localparam int TAG_BYTE_W = 8;
  localparam int TAG_W      = 5;
  localparam int STATUS_W   = 3;
  localparam int FILL_OUT_W = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 1;

  // item modes and read targets
  localparam logic MODE_PUSH    = 1'b0;
  localparam logic MODE_READ    = 1'b1;
  localparam logic SENSOR_GYRO  = 1'b0;
  localparam logic SENSOR_ACCEL = 1'b1;

  // tags in bits 7..3 of the tag byte
  localparam logic [TAG_W-1:0] TAG_GYRO  = 5'd1;
  localparam logic [TAG_W-1:0] TAG_ACCEL = 5'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GYRO_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEL_EN = 2'd1;

  // result status codes
  localparam logic [STATUS_W-1:0] STS_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] STS_DROP_FULL = 3'd1;
  localparam logic [STATUS_W-1:0] STS_DROP_TAG  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_READ_OK   = 3'd3;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 3'd4;
  localparam logic [STATUS_W-1:0] STS_READ_DIS  = 3'd5;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_LOAD
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
    logic emit;
  } tsdf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_stall;
  } tsdf_stat_t;

endpackage

[rtl/tsdf_req_if.sv]
// request channel: one push word or one read request per beat
`timescale 1ns / 1ps

interface tsdf_req_if;
  logic                            valid;
  logic                            ready;
  logic                            mode;
  logic [tsdf_pkg::TAG_BYTE_W-1:0] tag_byte;
  logic [tsdf_pkg::SAMPLE_W-1:0]   sample_in;
  logic                            sensor;

  modport source (output valid, mode, tag_byte, sample_in, sensor, input ready);
  modport sink   (input valid, mode, tag_byte, sample_in, sensor, output ready);
endinterface

[rtl/tsdf_rsp_if.sv]
// response channel: one result per beat
`timescale 1ns / 1ps

interface tsdf_rsp_if;
  logic                            valid;
  logic                            ready;
  logic [tsdf_pkg::STATUS_W-1:0]   status;
  logic [tsdf_pkg::SAMPLE_W-1:0]   sample_out;
  logic [tsdf_pkg::FILL_OUT_W-1:0] fill_level;

  modport source (output valid, status, sample_out, fill_level, input ready);
  modport sink   (input valid, status, sample_out, fill_level, output ready);
endinterface

[rtl/tsdf_ctrl.sv]
// sequencing state machine: accept, execute, load the response register
`timescale 1ns / 1ps

module tsdf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  tsdf_pkg::tsdf_stat_t stat,
  output tsdf_pkg::tsdf_cmd_t  cmd
);

  tsdf_pkg::state_t state;
  tsdf_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tsdf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      tsdf_pkg::ST_IDLE: begin
        if (in_valid) state_next = tsdf_pkg::ST_EXEC;
      end
      tsdf_pkg::ST_EXEC: begin
        state_next = tsdf_pkg::ST_LOAD;
      end
      tsdf_pkg::ST_LOAD: begin
        if (!stat.out_stall) state_next = tsdf_pkg::ST_IDLE;
      end
      default: begin
        state_next = tsdf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state)
      tsdf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      tsdf_pkg::ST_EXEC: begin
        cmd.exec = 1'b1;
      end
      tsdf_pkg::ST_LOAD: begin
        cmd.emit = !stat.out_stall;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/tsdf_datapath.sv]
// item register, two ring-buffer queues with pointers, response register
`timescale 1ns / 1ps

module tsdf_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  tsdf_pkg::tsdf_cmd_t                 cmd,
  output tsdf_pkg::tsdf_stat_t                stat,
  input  logic                                cfg_we,
  input  logic [tsdf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tsdf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_mode,
  input  logic [tsdf_pkg::TAG_BYTE_W-1:0]     in_tag_byte,
  input  logic [tsdf_pkg::SAMPLE_W-1:0]       in_sample,
  input  logic                                in_sensor,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tsdf_pkg::STATUS_W-1:0]       out_status,
  output logic [tsdf_pkg::SAMPLE_W-1:0]       out_sample,
  output logic [tsdf_pkg::FILL_OUT_W-1:0]     out_fill
);

  localparam int GPW = tsdf_pkg::G_PW;
  localparam int APW = tsdf_pkg::A_PW;
  localparam int GAW = tsdf_pkg::G_AW;
  localparam int AAW = tsdf_pkg::A_AW;

  // captured item
  logic                            item_mode;
  logic [tsdf_pkg::TAG_BYTE_W-1:0] item_tag_byte;
  logic [tsdf_pkg::SAMPLE_W-1:0]   item_sample;
  logic                            item_sensor;

  logic gyro_en;
  logic accel_en;
  logic [GPW-1:0] gyro_head;
  logic [GPW-1:0] gyro_tail;
  logic [APW-1:0] accel_head;
  logic [APW-1:0] accel_tail;

  logic [tsdf_pkg::SAMPLE_W-1:0] gyro_mem  [tsdf_pkg::GYRO_DEPTH];
  logic [tsdf_pkg::SAMPLE_W-1:0] accel_mem [tsdf_pkg::ACCEL_DEPTH];
  logic [tsdf_pkg::SAMPLE_W-1:0] gyro_rdata;
  logic [tsdf_pkg::SAMPLE_W-1:0] accel_rdata;

  logic [tsdf_pkg::STATUS_W-1:0]   res_status;
  logic [tsdf_pkg::FILL_OUT_W-1:0] res_fill;
  logic                            res_ok;

  logic [GPW-1:0] gyro_fill;
  logic [APW-1:0] accel_fill;
  logic [GPW-1:0] gyro_head_next;
  logic [GPW-1:0] gyro_tail_next;
  logic [APW-1:0] accel_head_next;
  logic [APW-1:0] accel_tail_next;
  logic [GAW-1:0] gyro_widx;
  logic [GAW-1:0] gyro_ridx;
  logic [AAW-1:0] accel_widx;
  logic [AAW-1:0] accel_ridx;
  logic [tsdf_pkg::TAG_W-1:0] tag;

  logic                            push_gyro;
  logic                            push_accel;
  logic                            pop_gyro;
  logic                            pop_accel;
  logic [tsdf_pkg::STATUS_W-1:0]   dec_status;
  logic [tsdf_pkg::FILL_OUT_W-1:0] dec_fill;
  logic                            dec_ok;

  // fill level modulo twice the depth
  always_comb begin
    gyro_fill = gyro_head - gyro_tail;
    if (gyro_head < gyro_tail) gyro_fill = gyro_head - gyro_tail + GPW'(2 * tsdf_pkg::GYRO_DEPTH);
    accel_fill = accel_head - accel_tail;
    if (accel_head < accel_tail) begin
      accel_fill = accel_head - accel_tail + APW'(2 * tsdf_pkg::ACCEL_DEPTH);
    end
  end

  // pointer advance with wrap at twice the depth
  always_comb begin
    gyro_head_next = ({1'b0, gyro_head} + (GPW+1)'(1) == (GPW+1)'(2 * tsdf_pkg::GYRO_DEPTH))
                     ? '0 : gyro_head + GPW'(1);
    gyro_tail_next = ({1'b0, gyro_tail} + (GPW+1)'(1) == (GPW+1)'(2 * tsdf_pkg::GYRO_DEPTH))
                     ? '0 : gyro_tail + GPW'(1);
    accel_head_next = ({1'b0, accel_head} + (APW+1)'(1) == (APW+1)'(2 * tsdf_pkg::ACCEL_DEPTH))
                      ? '0 : accel_head + APW'(1);
    accel_tail_next = ({1'b0, accel_tail} + (APW+1)'(1) == (APW+1)'(2 * tsdf_pkg::ACCEL_DEPTH))
                      ? '0 : accel_tail + APW'(1);
  end

  // storage index from a pointer
  always_comb begin
    gyro_widx = (gyro_head >= GPW'(tsdf_pkg::GYRO_DEPTH))
                ? GAW'(gyro_head - GPW'(tsdf_pkg::GYRO_DEPTH)) : GAW'(gyro_head);
    gyro_ridx = (gyro_tail >= GPW'(tsdf_pkg::GYRO_DEPTH))
                ? GAW'(gyro_tail - GPW'(tsdf_pkg::GYRO_DEPTH)) : GAW'(gyro_tail);
    accel_widx = (accel_head >= APW'(tsdf_pkg::ACCEL_DEPTH))
                 ? AAW'(accel_head - APW'(tsdf_pkg::ACCEL_DEPTH)) : AAW'(accel_head);
    accel_ridx = (accel_tail >= APW'(tsdf_pkg::ACCEL_DEPTH))
                 ? AAW'(accel_tail - APW'(tsdf_pkg::ACCEL_DEPTH)) : AAW'(accel_tail);
  end

  assign tag = item_tag_byte[7:3];

  // decide what the captured item does
  always_comb begin
    push_gyro  = 1'b0;
    push_accel = 1'b0;
    pop_gyro   = 1'b0;
    pop_accel  = 1'b0;
    dec_status = tsdf_pkg::STS_DROP_TAG;
    dec_fill   = '0;
    dec_ok     = 1'b0;
    if (item_mode == tsdf_pkg::MODE_PUSH) begin
      if (tag == tsdf_pkg::TAG_GYRO && gyro_en) begin
        if (gyro_fill >= GPW'(tsdf_pkg::GYRO_DEPTH)) begin
          dec_status = tsdf_pkg::STS_DROP_FULL;
          dec_fill   = tsdf_pkg::FILL_OUT_W'(gyro_fill);
        end else begin
          push_gyro  = 1'b1;
          dec_status = tsdf_pkg::STS_STORED;
          dec_fill   = tsdf_pkg::FILL_OUT_W'(gyro_fill + GPW'(1));
        end
      end else if (tag == tsdf_pkg::TAG_ACCEL && accel_en) begin
        if (accel_fill >= APW'(tsdf_pkg::ACCEL_DEPTH)) begin
          dec_status = tsdf_pkg::STS_DROP_FULL;
          dec_fill   = tsdf_pkg::FILL_OUT_W'(accel_fill);
        end else begin
          push_accel = 1'b1;
          dec_status = tsdf_pkg::STS_STORED;
          dec_fill   = tsdf_pkg::FILL_OUT_W'(accel_fill + APW'(1));
        end
      end
    end else if (item_sensor == tsdf_pkg::SENSOR_GYRO) begin
      if (!gyro_en) begin
        dec_status = tsdf_pkg::STS_READ_DIS;
      end else if (gyro_fill == '0) begin
        dec_status = tsdf_pkg::STS_EMPTY;
      end else begin
        pop_gyro   = 1'b1;
        dec_ok     = 1'b1;
        dec_status = tsdf_pkg::STS_READ_OK;
        dec_fill   = tsdf_pkg::FILL_OUT_W'(gyro_fill - GPW'(1));
      end
    end else begin
      if (!accel_en) begin
        dec_status = tsdf_pkg::STS_READ_DIS;
      end else if (accel_fill == '0) begin
        dec_status = tsdf_pkg::STS_EMPTY;
      end else begin
        pop_accel  = 1'b1;
        dec_ok     = 1'b1;
        dec_status = tsdf_pkg::STS_READ_OK;
        dec_fill   = tsdf_pkg::FILL_OUT_W'(accel_fill - APW'(1));
      end
    end
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item_mode     <= in_mode;
      item_tag_byte <= in_tag_byte;
      item_sample   <= in_sample;
      item_sensor   <= in_sensor;
    end
  end

  // enables and pointers; a register write empties its queue
  always_ff @(posedge clk) begin
    if (rst) begin
      gyro_en    <= 1'b0;
      accel_en   <= 1'b0;
      gyro_head  <= '0;
      gyro_tail  <= '0;
      accel_head <= '0;
      accel_tail <= '0;
    end else begin
      if (cmd.exec && push_gyro)  gyro_head  <= gyro_head_next;
      if (cmd.exec && pop_gyro)   gyro_tail  <= gyro_tail_next;
      if (cmd.exec && push_accel) accel_head <= accel_head_next;
      if (cmd.exec && pop_accel)  accel_tail <= accel_tail_next;
      if (cfg_we && cfg_index == tsdf_pkg::CFG_GYRO_EN) begin
        gyro_en   <= cfg_data[0];
        gyro_head <= '0;
        gyro_tail <= '0;
      end
      if (cfg_we && cfg_index == tsdf_pkg::CFG_ACCEL_EN) begin
        accel_en   <= cfg_data[0];
        accel_head <= '0;
        accel_tail <= '0;
      end
    end
  end

  // sample memories, registered read at the tail
  always_ff @(posedge clk) begin
    if (cmd.exec && push_gyro) gyro_mem[gyro_widx] <= item_sample;
    if (cmd.exec) gyro_rdata <= gyro_mem[gyro_ridx];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && push_accel) accel_mem[accel_widx] <= item_sample;
    if (cmd.exec) accel_rdata <= accel_mem[accel_ridx];
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= dec_status;
      res_fill   <= dec_fill;
      res_ok     <= dec_ok;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status <= res_status;
      out_fill   <= res_fill;
      if (!res_ok) begin
        out_sample <= '0;
      end else if (item_sensor == tsdf_pkg::SENSOR_ACCEL) begin
        out_sample <= accel_rdata;
      end else begin
        out_sample <= gyro_rdata;
      end
    end
  end

  assign stat.out_stall = out_valid && !out_ready;

  gyro_fill_bound: assert property (@(posedge clk) disable iff (rst)
    gyro_fill <= GPW'(tsdf_pkg::GYRO_DEPTH))
    else $error("gyro queue holds more than its depth");

  accel_fill_bound: assert property (@(posedge clk) disable iff (rst)
    accel_fill <= APW'(tsdf_pkg::ACCEL_DEPTH))
    else $error("accel queue holds more than its depth");

  emit_shows_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("response register not valid after load");

  gyro_cfg_clears: assert property (@(posedge clk) disable iff (rst)
    (cfg_we && cfg_index == tsdf_pkg::CFG_GYRO_EN) |=> (gyro_head == '0 && gyro_tail == '0))
    else $error("gyro pointers not cleared by register write");

endmodule

[rtl/tagged_sample_demux_fifo.sv]
// top level: tagged sample demux into gyroscope and accelerometer queues
`timescale 1ns / 1ps

// usage
//   req channel: one beat is either a push of a tagged fifo word (mode 0) or
//   a read request for one sensor (mode 1, sensor 0 gyro, 1 accel)
//   rsp channel: exactly one beat per request, with status, popped sample
//   (zero unless a read succeeded) and fill level of the addressed queue
//   cfg port: cfg_we with cfg_index 0 (gyro) or 1 (accel) writes the enable
//   from cfg_data bit 0 and empties that queue; other indexes are ignored
// timing
//   a request is taken, executed against its queue, then loaded into the
//   response register; the sample memory read is registered, and the
//   sequencer takes a new request only once it is idle again, after the
//   last result is loaded into the response register
//   req ready is high whenever the sequencer is idle, also while an earlier
//   response still waits in the response register
// reset
//   rst clears both enables and all pointers; queues start disabled and empty
//   memory contents are not cleared, only written entries are ever read
// stalls
//   while rsp is not ready the finished result waits in the sequencer and the
//   response register holds; nothing is lost or dropped

module tagged_sample_demux_fifo (
  input  logic                            clk,
  input  logic                            rst,
  tsdf_req_if.sink                        req,
  tsdf_rsp_if.source                      rsp,
  input  logic                            cfg_we,
  input  logic [tsdf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tsdf_pkg::CFG_DATA_W-1:0] cfg_data
);

  tsdf_pkg::tsdf_cmd_t  cmd;
  tsdf_pkg::tsdf_stat_t stat;

  // sequencer: idle, execute, load response
  tsdf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // queues, pointers and response register
  tsdf_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_mode     (req.mode),
    .in_tag_byte (req.tag_byte),
    .in_sample   (req.sample_in),
    .in_sensor   (req.sensor),
    .out_valid   (rsp.valid),
    .out_ready   (rsp.ready),
    .out_status  (rsp.status),
    .out_sample  (rsp.sample_out),
    .out_fill    (rsp.fill_level)
  );

endmodule

[test/tsdf_checker.sv]
// checker for the tagged sample demux fifo: predicts every response beat and compares it
`timescale 1ns / 1ps

module tsdf_checker
  import tsdf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  tsdf_req_if                  req,
  tsdf_rsp_if                  rsp,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                   owed_count,
  output int                   error_count
);

  localparam int MAX_DEPTH = (GYRO_DEPTH > ACCEL_DEPTH) ? GYRO_DEPTH : ACCEL_DEPTH;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SAMPLE_W-1:0]   sample;
    logic [FILL_OUT_W-1:0] fill;
  } rsp_beat_t;

  // shadow copy of both queues, indexed by sensor
  logic [SAMPLE_W-1:0] samples [2][MAX_DEPTH];
  int                  head [2];
  int                  tail [2];
  logic                enabled [2];
  rsp_beat_t           owed [$];

  initial error_count = 0;

  function automatic int depth_of(input logic sel);
    return (sel == SENSOR_ACCEL) ? ACCEL_DEPTH : GYRO_DEPTH;
  endfunction

  // pointers run modulo twice the depth
  function automatic int held(input logic sel);
    int span;
    span = 2 * depth_of(sel);
    return (head[sel] + span - tail[sel]) % span;
  endfunction

  function automatic int advance(input logic sel, input int p);
    return (p + 1 >= 2 * depth_of(sel)) ? 0 : p + 1;
  endfunction

  function automatic int slot(input logic sel, input int p);
    return (p >= depth_of(sel)) ? p - depth_of(sel) : p;
  endfunction

  // one request beat against the shadow queues
  function automatic rsp_beat_t demux_step(input logic mode_v,
                                           input logic [TAG_BYTE_W-1:0] tag_v,
                                           input logic [SAMPLE_W-1:0] smp_v,
                                           input logic sen_v);
    rsp_beat_t        r;
    logic [TAG_W-1:0] tag;
    logic             sel;
    logic             hit;
    r   = '0;
    sel = sen_v;
    hit = 1'b1;
    if (mode_v == MODE_PUSH) begin
      tag = tag_v[TAG_BYTE_W-1 -: TAG_W];
      if (tag == TAG_GYRO) sel = SENSOR_GYRO;
      else if (tag == TAG_ACCEL) sel = SENSOR_ACCEL;
      else hit = 1'b0;
      if (!hit || !enabled[sel]) begin
        r.status = STS_DROP_TAG;
      end else if (held(sel) >= depth_of(sel)) begin
        r.status = STS_DROP_FULL;
        r.fill   = FILL_OUT_W'(held(sel));
      end else begin
        samples[sel][slot(sel, head[sel])] = smp_v;
        head[sel] = advance(sel, head[sel]);
        r.status  = STS_STORED;
        r.fill    = FILL_OUT_W'(held(sel));
      end
    end else begin
      if (!enabled[sel]) begin
        r.status = STS_READ_DIS;
      end else if (held(sel) == 0) begin
        r.status = STS_EMPTY;
      end else begin
        r.sample  = samples[sel][slot(sel, tail[sel])];
        tail[sel] = advance(sel, tail[sel]);
        r.status  = STS_READ_OK;
        r.fill    = FILL_OUT_W'(held(sel));
      end
    end
    return r;
  endfunction

  // one line per mismatch
  task automatic flag_mismatch(input string what, input logic [63:0] got,
                               input logic [63:0] exp);
    $display("[%0t] mismatch %s: got %0h expected %0h", $time, what, got, exp);
    error_count++;
  endtask

  always @(posedge clk) begin : watch
    rsp_beat_t seen;
    rsp_beat_t want;
    logic      sel;
    if (rst) begin
      owed.delete();
      for (int i = 0; i < 2; i++) begin
        head[i]    = 0;
        tail[i]    = 0;
        enabled[i] = 1'b0;
      end
    end else begin
      // responses first: a beat never answers a request taken on the same edge
      if (rsp.valid && rsp.ready) begin
        seen.status = rsp.status;
        seen.sample = rsp.sample_out;
        seen.fill   = rsp.fill_level;
        if (owed.size() == 0) begin
          flag_mismatch("response beat with none outstanding", 64'(seen.status), '0);
        end else begin
          want = owed.pop_front();
          if (seen.status !== want.status)
            flag_mismatch("status", 64'(seen.status), 64'(want.status));
          if (seen.sample !== want.sample)
            flag_mismatch("sample_out", 64'(seen.sample), 64'(want.sample));
          if (seen.fill !== want.fill)
            flag_mismatch("fill_level", 64'(seen.fill), 64'(want.fill));
        end
      end
      if (cfg_we && (cfg_index == CFG_GYRO_EN || cfg_index == CFG_ACCEL_EN)) begin
        sel          = (cfg_index == CFG_ACCEL_EN) ? SENSOR_ACCEL : SENSOR_GYRO;
        enabled[sel] = cfg_data[0];
        head[sel]    = 0;
        tail[sel]    = 0;
      end
      if (req.valid && req.ready)
        owed.push_back(demux_step(req.mode, req.tag_byte, req.sample_in, req.sensor));
    end
    owed_count <= owed.size();
  end

endmodule

[test/tb.sv]
// testbench top for the tagged sample demux fifo: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import tsdf_pkg::*;

  // register indexes the block has no register behind
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_HI = 2'd3;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    owed_count;
  int                    error_count;
  int                    beats_sent;
  bit                    calm;

  tsdf_req_if req ();
  tsdf_rsp_if rsp ();

  tagged_sample_demux_fifo dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // watches both channels and the register port, predicts and compares
  tsdf_checker chk (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .owed_count  (owed_count),
    .error_count (error_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // hard stop far beyond the slowest legal run
  initial begin
    #(12 * 800_000);
    $display("Regression FAIL");
    $finish;
  end

  // idle length: mostly none, often short, now and then long
  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // random payload, with the all-zero and all-one extremes mixed in
  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [63:0] w;
    int          roll;
    roll = $urandom_range(0, 19);
    w    = {$urandom(), $urandom()};
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return w[SAMPLE_W-1:0];
  endfunction

  // response side: runs of ready with stalls of random length between them
  initial begin
    int hold;
    int stall;
    rsp.ready <= 1'b0;
    forever begin
      hold = $urandom_range(1, 40);
      repeat (hold) begin
        @(posedge clk);
        rsp.ready <= 1'b1;
      end
      stall = idle_gap();
      repeat (stall) begin
        @(posedge clk);
        rsp.ready <= 1'b0;
      end
    end
  end

  // one request beat; valid stays high on return so back-to-back beats need no dip
  task automatic send_beat(input logic mode_v, input logic [TAG_BYTE_W-1:0] tag_v,
                           input logic [SAMPLE_W-1:0] smp_v, input logic sen_v);
    int gap;
    gap = calm ? 0 : idle_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid     <= 1'b1;
    req.mode      <= mode_v;
    req.tag_byte  <= tag_v;
    req.sample_in <= smp_v;
    req.sensor    <= sen_v;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    beats_sent++;
  endtask

  // push a well-formed word for one sensor; the sensor field rides along ignored
  task automatic push_word(input logic sel, input logic [SAMPLE_W-1:0] smp);
    logic [TAG_W-1:0]            tag;
    logic [TAG_BYTE_W-TAG_W-1:0] low;
    tag = (sel == SENSOR_ACCEL) ? TAG_ACCEL : TAG_GYRO;
    low = (TAG_BYTE_W-TAG_W)'($urandom_range(0, 7));
    send_beat(MODE_PUSH, {tag, low}, smp, 1'($urandom_range(0, 1)));
  endtask

  // read request; tag byte and payload carry garbage the block must ignore
  task automatic read_sample(input logic sel);
    send_beat(MODE_READ, TAG_BYTE_W'($urandom_range(0, 255)), rand_sample(), sel);
  endtask

  // noise that leaves the queue not named by other alone: unknown tags or traffic for queue other
  task automatic stray_beat(input logic other);
    logic [TAG_BYTE_W-1:0] tag_v;
    case ($urandom_range(0, 2))
      0: begin
        do tag_v = TAG_BYTE_W'($urandom_range(0, 255));
        while (tag_v[TAG_BYTE_W-1 -: TAG_W] == TAG_GYRO ||
               tag_v[TAG_BYTE_W-1 -: TAG_W] == TAG_ACCEL);
        send_beat(MODE_PUSH, tag_v, rand_sample(), 1'($urandom_range(0, 1)));
      end
      1: push_word(other, rand_sample());
      default: read_sample(other);
    endcase
  endtask

  // hold the sender until every predicted beat has come back
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (owed_count != 0) @(posedge clk);
  endtask

  // register write, only ever with the block idle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // push one queue, then read it, each its depth plus one to four times; about one beat in ten is a stray
  task automatic fill_then_drain(input logic sel);
    int n;
    n = ((sel == SENSOR_ACCEL) ? ACCEL_DEPTH : GYRO_DEPTH) + $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) stray_beat(~sel);
      else push_word(sel, rand_sample());
    end
    n = ((sel == SENSOR_ACCEL) ? ACCEL_DEPTH : GYRO_DEPTH) + $urandom_range(1, 4);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) stray_beat(~sel);
      else read_sample(sel);
    end
  endtask

  // mixed pushes and reads on both queues with a random push/read balance
  task automatic mixed_traffic(input int n);
    int   push_pct;
    logic sel;
    push_pct = $urandom_range(25, 75);
    repeat (n) begin
      sel = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 99) < 6) stray_beat(sel);
      else if ($urandom_range(0, 99) < push_pct) push_word(sel, rand_sample());
      else read_sample(sel);
    end
  endtask

  // new enable setting; a write to an enable always empties its queue, even when it stays on
  task automatic reshuffle_enables();
    if ($urandom_range(0, 4) == 0)
      write_reg($urandom_range(0, 1) ? CFG_UNUSED_HI : CFG_UNUSED_LO,
                1'($urandom_range(0, 1)));
    if ($urandom_range(0, 3) != 0) write_reg(CFG_GYRO_EN, $urandom_range(0, 5) != 0);
    if ($urandom_range(0, 3) != 0) write_reg(CFG_ACCEL_EN, $urandom_range(0, 5) != 0);
  endtask

  initial begin
    beats_sent    = 0;
    calm          = 1'b0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_GYRO_EN;
    cfg_data      <= '0;
    req.valid     <= 1'b0;
    req.mode      <= MODE_PUSH;
    req.tag_byte  <= '0;
    req.sample_in <= '0;
    req.sensor    <= SENSOR_GYRO;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // out of reset both queues are off
    read_sample(SENSOR_GYRO);
    read_sample(SENSOR_ACCEL);
    push_word(SENSOR_GYRO, '1);
    push_word(SENSOR_ACCEL, '1);
    write_reg(CFG_GYRO_EN, 1'b1);
    write_reg(CFG_ACCEL_EN, 1'b1);

    // unknown tags, including tag zero and the all-ones tag
    send_beat(MODE_PUSH, '0, '1, SENSOR_GYRO);
    send_beat(MODE_PUSH, '1, '1, SENSOR_ACCEL);
    send_beat(MODE_PUSH, {TAG_ACCEL + 1'b1, 3'b000}, '0, SENSOR_ACCEL);

    // empty reads, then payload extremes through both queues
    read_sample(SENSOR_GYRO);
    read_sample(SENSOR_ACCEL);
    send_beat(MODE_PUSH, {TAG_GYRO, 3'b111}, '1, SENSOR_ACCEL);
    send_beat(MODE_PUSH, {TAG_GYRO, 3'b000}, '0, SENSOR_ACCEL);
    send_beat(MODE_PUSH, {TAG_ACCEL, 3'b101}, 48'h8000_0000_0001, SENSOR_GYRO);
    send_beat(MODE_READ, '1, '1, SENSOR_GYRO);
    send_beat(MODE_READ, '0, '0, SENSOR_GYRO);
    read_sample(SENSOR_GYRO);
    read_sample(SENSOR_ACCEL);

    // rewriting an enable empties a queue that still holds a sample
    push_word(SENSOR_GYRO, rand_sample());
    write_reg(CFG_GYRO_EN, 1'b1);
    read_sample(SENSOR_GYRO);

    // disabled accel queue, and writes to indexes with no register behind them
    write_reg(CFG_ACCEL_EN, 1'b0);
    push_word(SENSOR_ACCEL, rand_sample());
    read_sample(SENSOR_ACCEL);
    write_reg(CFG_UNUSED_LO, 1'b0);
    write_reg(CFG_UNUSED_HI, 1'b1);
    push_word(SENSOR_GYRO, rand_sample());
    read_sample(SENSOR_GYRO);
    write_reg(CFG_ACCEL_EN, 1'b1);

    // two rounds on gyro carry its pointers past the depth into the upper half of their range
    fill_then_drain(SENSOR_GYRO);
    fill_then_drain(SENSOR_GYRO);
    fill_then_drain(SENSOR_ACCEL);

    // random phases; every register write doubles as a full drain pause
    while (beats_sent < 1600) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 9))
        0, 1: reshuffle_enables();
        default: mixed_traffic($urandom_range(30, 120));
      endcase
    end
    calm = 1'b0;

    // let every outstanding beat come back, then watch a little longer
    wait_drained();
    repeat (10) @(posedge clk);
    if (error_count == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
